>>> sv/assert_macros.svh
// Assertion macros for the RTL of the move-to-front list.
// No dependencies; define NO_ASSERTIONS to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Expression must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> sv/mtf_pkg.sv
// Types and constants of the move-to-front list.
// Used by mtf_core and the top level move_to_front_list.
`timescale 1ns / 1ps

package mtf_pkg;

  localparam int TDATA_IN_W  = 40;
  localparam int TDATA_OUT_W = 40;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_SEARCH = 1'b1
  } mtf_req_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } mtf_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RIPPLE,
    ST_DONE
  } mtf_state_e;

  typedef struct packed {
    mtf_req_e    req_type;
    logic [4:0]  position;
    logic [31:0] value;
  } mtf_req_t;

  typedef struct packed {
    logic [4:0]  found_position;
    mtf_status_e status;
    logic [31:0] total_cost;
  } mtf_res_t;

endpackage

>>> sv/mtf_core.sv
// Sequencer and entry memory of the move-to-front list.
// Depends on mtf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mtf_core #(
  parameter int DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  mtf_pkg::mtf_req_t req_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output mtf_pkg::mtf_res_t res_o
);
  import mtf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > 5) ? CW : 5) + 1;

  mtf_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0] cost_q, cost_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] end_q, end_d;
  logic [31:0] carry_q, carry_d;
  mtf_res_t res_q, res_d;

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;
  logic rd_en;
  logic [AW-1:0] rd_addr;
  logic we;
  logic [AW-1:0] wr_addr;
  logic [31:0] wdata;

  logic [4:0] pos_eff;
  logic [4:0] idx_in;
  logic list_full;
  logic pos_beyond;
  logic [CW-1:0] found_cnt;
  logic [32:0] cost_sum;
  logic [31:0] cost_new;

  // Position zero means the front of the list.
  assign pos_eff    = (req_i.position == 5'd0) ? 5'd1 : req_i.position;
  assign idx_in     = pos_eff - 5'd1;
  assign list_full  = (count_q == CW'(DEPTH));
  assign pos_beyond = PW'(pos_eff) > (PW'(count_q) + PW'(1));

  assign found_cnt = CW'(ptr_q) + CW'(1);
  assign cost_sum  = {1'b0, cost_q} + 33'(found_cnt);
  assign cost_new  = cost_sum[32] ? 32'hFFFF_FFFF : cost_sum[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      cost_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      cost_q  <= cost_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q   <= ptr_d;
    end_q   <= end_d;
    carry_q <= carry_d;
    res_q   <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // A ripple pass writes each entry with the value read one place earlier,
  // carrying the displaced value on to the next entry.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cost_d      = cost_q;
    ptr_d       = ptr_q;
    end_d       = end_q;
    carry_d     = carry_q;
    res_d       = res_q;
    rd_en       = 1'b0;
    rd_addr     = ptr_q;
    we          = 1'b0;
    wr_addr     = ptr_q;
    wdata       = carry_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          res_d.found_position = 5'd0;
          res_d.status         = STATUS_OK;
          res_d.total_cost     = cost_q;
          carry_d              = req_i.value;
          if (req_i.req_type == REQ_INSERT) begin
            if (list_full) begin
              res_d.status = STATUS_FULL;
              state_d      = ST_DONE;
            end else if (pos_beyond) begin
              res_d.status = STATUS_RANGE;
              state_d      = ST_DONE;
            end else begin
              ptr_d   = AW'(idx_in);
              end_d   = AW'(count_q);
              count_d = count_q + CW'(1);
              rd_en   = 1'b1;
              rd_addr = AW'(idx_in);
              state_d = ST_RIPPLE;
            end
          end else begin
            ptr_d = '0;
            if (count_q == '0) begin
              state_d = ST_DONE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = '0;
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (rdata_q == carry_q) begin
          res_d.found_position = 5'(found_cnt);
          res_d.total_cost     = cost_new;
          cost_d               = cost_new;
          if (ptr_q == '0) begin
            state_d = ST_DONE;
          end else begin
            end_d   = ptr_q;
            ptr_d   = '0;
            rd_en   = 1'b1;
            rd_addr = '0;
            state_d = ST_RIPPLE;
          end
        end else if (found_cnt == count_q) begin
          state_d = ST_DONE;
        end else begin
          ptr_d   = ptr_q + AW'(1);
          rd_en   = 1'b1;
          rd_addr = ptr_q + AW'(1);
        end
      end
      ST_RIPPLE: begin
        we      = 1'b1;
        carry_d = rdata_q;
        if (ptr_q == end_q) begin
          state_d = ST_DONE;
        end else begin
          ptr_d   = ptr_q + AW'(1);
          rd_en   = 1'b1;
          rd_addr = ptr_q + AW'(1);
        end
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

  `ASSERT_ALWAYS(a_rw_apart, clk_i, rst_ni, !(we && rd_en && (wr_addr == rd_addr)), "read and write hit the same entry")
  `ASSERT_ALWAYS(a_count_range, clk_i, rst_ni, count_q <= CW'(DEPTH), "entry count above depth")
  `ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_o && !res_ready_i, res_valid_o && $stable(res_q), "result changed while stalled")
  `ASSERT_ALWAYS(a_err_no_hit, clk_i, rst_ni, !res_valid_o || (res_q.status == STATUS_OK) || (res_q.found_position == 5'd0), "failed insert reports a position")

endmodule

>>> sv/move_to_front_list.sv
// Top level of the move-to-front list: stream ports and output register.
// Depends on mtf_pkg and mtf_core.
`timescale 1ns / 1ps

// Move-to-front list of up to DEPTH signed 32-bit entries.
// Input items arrive on s_axis: tuser selects insert (0) or search (1), tdata
// carries the 1-based insert position and the value or search key. Every item
// yields exactly one result item on m_axis with the found position, a status
// code and the saturating total of all found positions since reset.
// Items are taken one at a time; the entries live in a single-port-read,
// single-port-write memory. A scan step reads one entry, a ripple step
// writes one. A search reads from the front until a hit or the end of the
// list; a hit at position k > 1 then rewrites the first k entries, moving
// the hit to the front. An insert at position p rewrites the entries from
// p to the new end of the list, each moving back by one place.
// The next item is accepted in the cycle after the result leaves the core.
// Reset empties the list and clears the total; no memory clearing is needed.
// An output register holds a finished result while m_axis_tready is low, so
// one further item can be worked on; after that s_axis_tready stays low.
module move_to_front_list #(
  parameter int DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // position [4:0], value [36:5], zero [39:37]
  input  logic [mtf_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
  // req_type [0]
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // found_position [4:0], status [6:5], total_cost [38:7], zero [39]
  output logic [mtf_pkg::TDATA_OUT_W-1:0]    m_axis_tdata
);
  import mtf_pkg::*;

  mtf_req_t req;
  mtf_res_t res;
  logic res_valid;
  logic res_ready;
  logic out_valid_q;
  mtf_res_t out_q;

  assign req.req_type = mtf_req_e'(s_axis_tuser);
  assign req.position = s_axis_tdata[4:0];
  assign req.value    = s_axis_tdata[36:5];

  mtf_core #(
    .DEPTH(DEPTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid),
    .req_ready_o(s_axis_tready),
    .req_i      (req),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.total_cost, out_q.status, out_q.found_position};

endmodule
